>>> sv/ffsot_pkg.sv
// Shared types and constants for the first-free slot owner table.
package ffsot_pkg;

  localparam int unsigned SEAT_W   = 7;
  localparam int unsigned PERSON_W = 16;
  localparam int unsigned CAP_W    = 7;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam int unsigned DEF_SEATS   = 64;
  localparam int unsigned DEF_ID_BITS = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [PERSON_W-1:0] person_id;
    logic [SEAT_W-1:0]   seat_number;
  } item_t;

  typedef struct packed {
    logic                ok;
    logic [SEAT_W-1:0]   seat;
    logic [PERSON_W-1:0] person;
    logic [CAP_W-1:0]    free_count;
    logic [CAP_W-1:0]    occupied_count;
  } result_t;

  // command broadcast to every cell while a word walks the row
  typedef struct packed {
    logic                en;
    op_e                 op;
    logic [PERSON_W-1:0] pid;
    logic [SEAT_W-1:0]   slot;
    logic [CAP_W-1:0]    cap;
  } cmd_t;

  // token handed from cell to cell
  typedef struct packed {
    logic                act;
    logic                found;
    logic [SEAT_W-1:0]   seat;
    logic [PERSON_W-1:0] person;
  } link_t;

endpackage

>>> sv/first_free_slot_owner_table_core.sv
// Top level of the first-free slot owner table: command port, APB port, cell row.
//
//   channel   signals                          handshake
//   command   item_i                           start high, busy low
//   result    result_o                         result_valid_o, one cycle
//   config    psel penable pwrite paddr pwdata psel & penable & pwrite, pready=1
//
// A new item is accepted only once the last one is done: a token walks the row
// of SEATS cells one cell a cycle and the result is registered behind the last
// cell. The result strobe rises as busy falls.
// Reset and capacity writes free every slot at once; no clearing pass.
// The receiver cannot stall; results are never held.
module first_free_slot_owner_table_core #(
  parameter int unsigned SEATS   = ffsot_pkg::DEF_SEATS,
  parameter int unsigned ID_BITS = ffsot_pkg::DEF_ID_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  ffsot_pkg::item_t                 item_i,
  output logic                             result_valid_o,
  output ffsot_pkg::result_t               result_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ffsot_pkg::PADDR_W-1:0]    paddr,
  input  logic [ffsot_pkg::PDATA_W-1:0]    pwdata,
  output logic [ffsot_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready
);

  localparam logic [ffsot_pkg::PERSON_W-1:0] IdMask =
    (ID_BITS >= ffsot_pkg::PERSON_W) ? '1
                                     : ffsot_pkg::PERSON_W'((64'd1 << ID_BITS) - 64'd1);

  logic [ffsot_pkg::CAP_W-1:0] cap_q, cap_d;
  logic [ffsot_pkg::CAP_W-1:0] used_q, used_d;
  logic [ffsot_pkg::CAP_W-1:0] cap_eff;
  logic                        busy_q, busy_d;
  logic                        launch_q;
  logic                        done_q;
  ffsot_pkg::cmd_t             cmd_q, cmd_d;
  ffsot_pkg::result_t          res_q, res_d;
  ffsot_pkg::link_t            link [SEATS+1];
  logic                        accept;
  logic                        cfg_wr;
  logic                        wipe;
  logic                        tail;
  logic [ffsot_pkg::PERSON_W-1:0] pid_m;
  logic                        slot_ok;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign wipe    = cfg_wr && (paddr[2] == ffsot_pkg::REG_CAPACITY);
  assign prdata  = (paddr[2] == ffsot_pkg::REG_CAPACITY)
                   ? ffsot_pkg::PDATA_W'(cap_q) : '0;

  assign cap_eff = (32'(cap_q) > SEATS) ? ffsot_pkg::CAP_W'(SEATS) : cap_q;
  assign accept  = start && !busy_q;
  assign tail    = link[SEATS].act;
  assign pid_m   = item_i.person_id & IdMask;
  assign slot_ok = (item_i.seat_number != '0) && (item_i.seat_number <= cap_eff);

  // command latch
  always_comb begin
    cmd_d      = cmd_q;
    cmd_d.op   = item_i.op;
    cmd_d.pid  = pid_m;
    cmd_d.slot = item_i.seat_number;
    cmd_d.cap  = cap_eff;
    unique case (item_i.op)
      ffsot_pkg::OP_RESERVE: cmd_d.en = (cap_eff != '0) && (pid_m != '0) &&
                                        (used_q < cap_eff);
      ffsot_pkg::OP_RELEASE,
      ffsot_pkg::OP_QUERY:   cmd_d.en = (cap_eff != '0) && slot_ok;
      ffsot_pkg::OP_CLEAR:   cmd_d.en = cap_eff != '0;
      default:               cmd_d.en = 1'b0;
    endcase
    if (!accept) begin
      cmd_d = cmd_q;
    end
  end

  // busy, capacity, result and occupancy update; results taken at the end of the row
  always_comb begin
    ffsot_pkg::link_t t;
    t      = link[SEATS];
    used_d = used_q;
    res_d  = res_q;
    busy_d = busy_q;
    cap_d  = cap_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (tail) begin
      busy_d       = 1'b0;
      res_d.seat   = cmd_q.slot;
      res_d.person = '0;
      res_d.ok     = 1'b0;
      unique case (cmd_q.op)
        ffsot_pkg::OP_RESERVE: begin
          res_d.ok   = t.found;
          res_d.seat = t.found ? t.seat : '0;
          if (t.found) begin
            used_d = used_q + ffsot_pkg::CAP_W'(1);
          end
        end
        ffsot_pkg::OP_RELEASE: begin
          res_d.person = t.person;
          res_d.ok     = cmd_q.en && (t.person != '0);
          if (res_d.ok && (used_q != '0)) begin
            used_d = used_q - ffsot_pkg::CAP_W'(1);
          end
        end
        ffsot_pkg::OP_QUERY: begin
          res_d.person = t.person;
          res_d.ok     = cmd_q.en;
        end
        ffsot_pkg::OP_CLEAR: begin
          res_d.ok = cmd_q.en;
          if (cmd_q.en) begin
            used_d = '0;
          end
        end
        default: begin
          res_d.ok = 1'b0;
        end
      endcase
      res_d.occupied_count = used_d;
      res_d.free_count     = (cap_eff >= used_d) ? cap_eff - used_d : '0;
    end
    if (wipe) begin
      cap_d  = pwdata[ffsot_pkg::CAP_W-1:0];
      used_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= ffsot_pkg::CAP_RESET;
      used_q   <= '0;
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      cap_q    <= cap_d;
      used_q   <= used_d;
      busy_q   <= busy_d;
      launch_q <= accept;
      done_q   <= tail;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  assign link[0] = '{act: launch_q, found: 1'b0, seat: '0, person: '0};

  for (genvar k = 0; k < SEATS; k++) begin : g_cell
    ffsot_cell #(
      .IDX     (k),
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wipe_i (wipe),
      .cmd_i  (cmd_q),
      .link_i (link[k]),
      .link_o (link[k+1])
    );
  end

  assign busy           = busy_q;
  assign result_valid_o = done_q;
  assign result_o       = res_q;

endmodule

>>> sv/ffsot_cell.sv
// One slot of the owner table: holds an owner id and forwards the token.
module ffsot_cell #(
  parameter int unsigned IDX     = 0,
  parameter int unsigned ID_BITS = ffsot_pkg::DEF_ID_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wipe_i,
  input  ffsot_pkg::cmd_t   cmd_i,
  input  ffsot_pkg::link_t  link_i,
  output ffsot_pkg::link_t  link_o
);

  logic [ID_BITS-1:0] owner_q, owner_d;
  ffsot_pkg::link_t   link_q, link_d;
  logic               in_cap;
  logic               hit;

  assign in_cap = IDX < 32'(cmd_i.cap);
  assign hit    = 32'(cmd_i.slot) == (IDX + 1);

  always_comb begin
    owner_d = owner_q;
    link_d  = link_i;
    if (wipe_i) begin
      owner_d = '0;
    end else if (link_i.act && cmd_i.en) begin
      unique case (cmd_i.op)
        ffsot_pkg::OP_RESERVE: begin
          if (!link_i.found && in_cap && (owner_q == '0)) begin
            owner_d      = ID_BITS'(cmd_i.pid);
            link_d.found = 1'b1;
            link_d.seat  = ffsot_pkg::SEAT_W'(IDX + 1);
          end
        end
        ffsot_pkg::OP_RELEASE: begin
          if (hit) begin
            link_d.person = ffsot_pkg::PERSON_W'(owner_q);
            owner_d       = '0;
          end
        end
        ffsot_pkg::OP_QUERY: begin
          if (hit) begin
            link_d.person = ffsot_pkg::PERSON_W'(owner_q);
          end
        end
        ffsot_pkg::OP_CLEAR: begin
          owner_d = '0;
        end
        default: begin
          owner_d = owner_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
      link_q  <= '0;
    end else begin
      owner_q <= owner_d;
      link_q  <= link_d;
    end
  end

  assign link_o = link_q;

endmodule
